[rtl/core/tks_pkg.sv]
package tks_pkg;

    // Store geometry.
    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Field widths.
    localparam int ID_W    = 23;
    localparam int KEY_W   = 64;
    localparam int RANK_W  = 5;
    localparam int TOP_N_W = 6;

    localparam logic [TOP_N_W-1:0] TOP_N_RESET = 6'd20;

    // Input item codes.
    typedef enum logic [0:0] {
        ACT_OFFER = 1'b0,
        ACT_END   = 1'b1
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [ID_W-1:0]    entry_id;
        logic [KEY_W-1:0]   entry_key;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]    out_id;
        logic [KEY_W-1:0]   out_key;
        logic [RANK_W-1:0]  rank;
        logic               last;
    } result_t;

    // One stored entry.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [KEY_W-1:0]   key;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIN_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_DRAIN_SCAN,
        ST_DRAIN_OUT
    } state_t;

endpackage

[rtl/core/top_k_largest_selector.sv]
// An offer into a store below its limit is written in the transfer cycle.
// A replacement offer runs a minimum scan and a decision, then compaction if its key
// beats the kept minimum; the store has one registered read port for the scans.
// A drain rescans for the largest unreported entry before each result it presents.
// Items are stalled outside the idle state, so no offer is taken mid-operation.
// Reset clears the kept count and sets the limit register to 20; no clearing pass.
module top_k_largest_selector
    import tks_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  item_t               item,
    output logic                result_valid,
    input  logic                result_stall,
    output result_t             result,
    input  logic                top_n_we,
    input  logic [TOP_N_W-1:0]  top_n_wdata
);

    // Entry store, one write port and one registered read port.
    entry_t mem [MAX_ENTRIES];

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [TOP_N_W-1:0]      top_n_reg;
    logic [CNT_W-1:0]        scan_reg, scan_next;
    logic                    d_valid_reg, d_valid_next;
    logic [IDX_W-1:0]        d_idx_reg;
    entry_t                  rd_data_reg;
    logic [ID_W-1:0]         item_id_reg, item_id_next;
    logic [KEY_W-1:0]        item_key_reg, item_key_next;
    logic [KEY_W-1:0]        min_key_reg, min_key_next;
    logic [IDX_W-1:0]        min_idx_reg, min_idx_next;
    entry_t                  best_reg, best_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic                    have_best_reg, have_best_next;
    logic [MAX_ENTRIES-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]        rank_reg, rank_next;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    entry_t                  mem_wdata;
    logic [IDX_W-1:0]        rd_addr;
    logic                    issue;
    logic [CNT_W-1:0]        lim;
    logic [CNT_W-1:0]        cnt_m1;
    logic                    in_xfer;
    logic                    out_xfer;
    logic                    is_last;

    // Effective limit is the register capped at the store depth.
    always_comb
    begin
        if (int'(top_n_reg) > MAX_ENTRIES)
            lim = CNT_W'(MAX_ENTRIES);
        else
            lim = CNT_W'(top_n_reg);
    end

    assign cnt_m1   = count_reg - CNT_W'(1);
    assign in_xfer  = item_valid && !item_stall;
    assign out_xfer = result_valid && !result_stall;
    assign issue    = (scan_reg < count_reg);
    assign rd_addr  = scan_reg[IDX_W-1:0];
    assign is_last  = (rank_reg == cnt_m1);

    // Handshake outputs and the result register view.
    assign item_stall     = (state_reg != ST_IDLE);
    assign result_valid   = (state_reg == ST_DRAIN_OUT);
    assign result.out_id  = best_reg.id;
    assign result.out_key = best_reg.key;
    assign result.rank    = rank_reg[RANK_W-1:0];
    assign result.last    = is_last;

    // Sequencer: next state, datapath updates and memory control.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        d_valid_next   = 1'b0;
        item_id_next   = item_id_reg;
        item_key_next  = item_key_reg;
        min_key_next   = min_key_reg;
        min_idx_next   = min_idx_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        have_best_next = have_best_reg;
        used_next      = used_reg;
        rank_next      = rank_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[IDX_W-1:0];
        mem_wdata      = '{id: item.entry_id, key: item.entry_key};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    item_id_next  = item.entry_id;
                    item_key_next = item.entry_key;
                    scan_next     = '0;
                    if (item.action == ACT_END)
                    begin
                        if (count_reg != '0)
                        begin
                            used_next      = '0;
                            rank_next      = '0;
                            have_best_next = 1'b0;
                            state_next     = ST_DRAIN_SCAN;
                        end
                    end
                    else if (lim != '0)
                    begin
                        if (count_reg < lim)
                        begin
                            // Room left: append directly.
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            state_next = ST_MIN_SCAN;
                        end
                    end
                end
            end

            ST_MIN_SCAN:
            begin
                // Smallest key, latest admitted on ties.
                d_valid_next = issue;
                if (issue)
                    scan_next = scan_reg + CNT_W'(1);
                if (d_valid_reg)
                begin
                    if ((d_idx_reg == '0) || (rd_data_reg.key <= min_key_reg))
                    begin
                        min_key_next = rd_data_reg.key;
                        min_idx_next = d_idx_reg;
                    end
                end
                else if (!issue)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (item_key_reg > min_key_reg)
                begin
                    scan_next  = CNT_W'(min_idx_reg) + CNT_W'(1);
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SHIFT:
            begin
                // Close the gap one entry a cycle, then write the new entry last.
                d_valid_next = issue;
                if (issue)
                    scan_next = scan_reg + CNT_W'(1);
                if (d_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = d_idx_reg - IDX_W'(1);
                    mem_wdata = rd_data_reg;
                end
                else if (!issue)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = cnt_m1[IDX_W-1:0];
                    mem_wdata  = '{id: item_id_reg, key: item_key_reg};
                    state_next = ST_IDLE;
                end
            end

            ST_DRAIN_SCAN:
            begin
                // Largest unreported key, earliest admitted on ties.
                d_valid_next = issue;
                if (issue)
                    scan_next = scan_reg + CNT_W'(1);
                if (d_valid_reg)
                begin
                    if (!used_reg[d_idx_reg] &&
                        (!have_best_reg || (rd_data_reg.key > best_reg.key)))
                    begin
                        best_next      = rd_data_reg;
                        best_idx_next  = d_idx_reg;
                        have_best_next = 1'b1;
                    end
                end
                else if (!issue)
                begin
                    state_next = ST_DRAIN_OUT;
                end
            end

            ST_DRAIN_OUT:
            begin
                if (out_xfer)
                begin
                    used_next[best_idx_reg] = 1'b1;
                    rank_next      = rank_reg + CNT_W'(1);
                    have_best_next = 1'b0;
                    scan_next      = '0;
                    if (is_last)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DRAIN_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            top_n_reg     <= TOP_N_RESET;
            d_valid_reg   <= 1'b0;
            have_best_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            d_valid_reg   <= d_valid_next;
            have_best_reg <= have_best_next;
            if (top_n_we)
                top_n_reg <= top_n_wdata;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        d_idx_reg    <= rd_addr;
        item_id_reg  <= item_id_next;
        item_key_reg <= item_key_next;
        min_key_reg  <= min_key_next;
        min_idx_reg  <= min_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        used_reg     <= used_next;
        rank_reg     <= rank_next;
    end

    // Entry memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

    // The kept count never exceeds the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("kept count exceeds store depth");

    // A result is only presented while entries are kept.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (count_reg != '0))
        else $error("result presented from an empty store");

    // The final transfer of a drain empties the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && result.last) |=> (count_reg == '0) && !result_valid)
        else $error("store not emptied after the last result");

    // Compaction never writes below slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SHIFT) && d_valid_reg) |-> (d_idx_reg != '0))
        else $error("compaction read at slot zero");

endmodule
